>>> hdl/kdeq_pkg.sv
// Shared types and constants for the key debounce event queue.
package kdeq_pkg;

  localparam int NUM_KEYS_DEF    = 8;
  localparam int RING_SLOTS_DEF  = 32;
  localparam int AGREE_THRESHOLD = 2;
  localparam int KEY_W           = 4;
  localparam int EVENT_W         = 4;
  localparam int CMD_DEPTH       = 2;

  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] key;
    logic             pressed;
  } kdeq_req_t;

  typedef struct packed {
    logic [EVENT_W-1:0] event_res;
    logic               queued;
    logic               dropped;
  } kdeq_res_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_POP,
    CMD_PUSH
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e            op;
    logic [EVENT_W-1:0] ev;
  } kdeq_cmd_t;

endpackage

>>> hdl/kdeq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kdeq_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/kdeq_front.sv
// Front end: accepts requests, debounces keys and classifies each request.
module kdeq_front #(
  parameter int NUM_KEYS = kdeq_pkg::NUM_KEYS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  kdeq_pkg::kdeq_req_t req_i,
  input  logic                fifo_full_i,
  output logic                busy_o,
  output logic                push_o,
  output kdeq_pkg::kdeq_cmd_t cmd_o
);
  import kdeq_pkg::*;

  localparam int KIW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic [NUM_KEYS-1:0] last_valid_q, last_level_q;
  logic [NUM_KEYS-1:0] settled_valid_q, settled_level_q;
  logic [1:0]          agree_q [NUM_KEYS];

  logic           accept;
  logic           in_range;
  logic [KIW-1:0] idx;
  logic           lvl;
  logic           same;
  logic [1:0]     agree_new;
  logic           settle;
  logic           upd;

  always_comb begin
    accept    = start_i && !fifo_full_i;
    in_range  = {1'b0, req_i.key} < (KEY_W+1)'(NUM_KEYS);
    idx       = req_i.key[KIW-1:0];
    lvl       = req_i.pressed;
    same      = in_range && last_valid_q[idx] && (last_level_q[idx] == lvl);
    agree_new = 2'd1;
    if (same) begin
      agree_new = (agree_q[idx] < 2'(AGREE_THRESHOLD)) ? agree_q[idx] + 2'd1 : agree_q[idx];
    end
    settle = (agree_new == 2'(AGREE_THRESHOLD));
    upd    = accept && !req_i.mode && in_range;
    cmd_o.op = CMD_NONE;
    cmd_o.ev = '0;
    if (req_i.mode) begin
      cmd_o.op = CMD_POP;
    end else if (in_range && settle && settled_valid_q[idx] &&
                 (settled_level_q[idx] != lvl) && lvl) begin
      cmd_o.op = CMD_PUSH;
      cmd_o.ev = EVENT_W'(req_i.key + 4'd1);
    end
  end

  assign busy_o = fifo_full_i;
  assign push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_valid_q    <= '0;
      last_level_q    <= '0;
      settled_valid_q <= '0;
      settled_level_q <= '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        agree_q[i] <= '0;
      end
    end else if (upd) begin
      last_valid_q[idx] <= 1'b1;
      last_level_q[idx] <= lvl;
      agree_q[idx]      <= agree_new;
      if (settle) begin
        settled_valid_q[idx] <= 1'b1;
        settled_level_q[idx] <= lvl;
      end
    end
  end

endmodule

>>> hdl/kdeq_cmd_fifo.sv
// Short command queue between front end and ring back end.
module kdeq_cmd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  kdeq_pkg::kdeq_cmd_t cmd_i,
  input  logic                pop_i,
  output kdeq_pkg::kdeq_cmd_t cmd_o,
  output logic                full_o,
  output logic                empty_o
);
  import kdeq_pkg::*;

  localparam int PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CW = $clog2(CMD_DEPTH + 1);

  kdeq_cmd_t      slot_q [CMD_DEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [CW-1:0]  cnt_q;

  function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
    return (p == PW'(CMD_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full_o  = (cnt_q == CW'(CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= nxt(wr_q);
      end
      if (pop_i) begin
        rd_q <= nxt(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("cmd fifo overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("cmd fifo underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CMD_DEPTH)) else $error("cmd fifo count out of range");

endmodule

>>> hdl/kdeq_back.sv
// Back end: carries out ring push and pop commands and drives results.
module kdeq_back #(
  parameter int RING_SLOTS = kdeq_pkg::RING_SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kdeq_pkg::kdeq_cmd_t cmd_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                done_o,
  output kdeq_pkg::kdeq_res_t res_o
);
  import kdeq_pkg::*;

  localparam int AW = $clog2(RING_SLOTS);

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  state_e             state_q;
  logic [AW-1:0]      wr_q, rd_q, wr_nxt, rd_nxt;
  logic               done_q;
  kdeq_res_t          res_q;
  logic               ring_full, ring_empty;
  logic               ram_we, ram_re;
  logic [EVENT_W-1:0] rdata;

  always_comb begin
    wr_nxt     = (wr_q == AW'(RING_SLOTS - 1)) ? '0 : wr_q + AW'(1);
    rd_nxt     = (rd_q == AW'(RING_SLOTS - 1)) ? '0 : rd_q + AW'(1);
    ring_full  = (wr_nxt == rd_q);
    ring_empty = (wr_q == rd_q);
    pop_o      = (state_q == ST_IDLE) && !empty_i;
    ram_we     = pop_o && (cmd_i.op == CMD_PUSH) && !ring_full;
    ram_re     = pop_o && (cmd_i.op == CMD_POP) && !ring_empty;
  end

  kdeq_ram #(
    .WIDTH (EVENT_W),
    .DEPTH (RING_SLOTS)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_q),
    .wdata_i (cmd_i.ev),
    .re_i    (ram_re),
    .raddr_i (rd_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wr_q    <= '0;
      rd_q    <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      done_q <= (state_q == ST_READ) || (pop_o && !ram_re);
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            res_q.event_res <= '0;
            res_q.queued    <= (cmd_i.op == CMD_PUSH) && !ring_full;
            res_q.dropped   <= (cmd_i.op == CMD_PUSH) && ring_full;
            if (ram_re) begin
              rd_q    <= rd_nxt;
              state_q <= ST_READ;
            end
            if (ram_we) begin
              wr_q <= wr_nxt;
            end
          end
        end
        ST_READ: begin
          res_q.event_res <= rdata;
          state_q         <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !(res_q.queued && res_q.dropped)) else $error("queued and dropped both set");
  a_event_no_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.event_res != '0) |-> (!res_q.queued && !res_q.dropped))
    else $error("event with sample flags");
  a_read_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> done_q) else $error("ring read gave no result");
  a_no_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re)) else $error("ring read and write together");

endmodule

>>> hdl/key_debounce_event_queue_core.sv
// Top level of the key debounce event queue.
// Usage:
//   A request (req_i: mode, key, pressed) is taken at a rising edge with
//   start_i high and busy_o low. mode 0 is a key sample, mode 1 a poll.
//   Every request gives exactly one result on res_o, marked by done_o for
//   one cycle, in request order. The receiver cannot stall.
//   The front end debounces keys in the accept cycle and puts a command in
//   a two-entry queue; the back end works the event ring memory.
// Timing: a command goes through the command queue to the back end, which
//   registers done_o and res_o; a poll that pops an event adds the ring
//   read state. Throughput: one sample per cycle unless the back end is in
//   its read state. busy_o is high while the command queue is full.
// Reset: all keys unsettled, ring empty, queue empty; no clearing pass.
module key_debounce_event_queue_core #(
  parameter int NUM_KEYS   = kdeq_pkg::NUM_KEYS_DEF,
  parameter int RING_SLOTS = kdeq_pkg::RING_SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  kdeq_pkg::kdeq_req_t req_i,
  output logic                busy_o,
  output logic                done_o,
  output kdeq_pkg::kdeq_res_t res_o
);
  import kdeq_pkg::*;

  kdeq_cmd_t cmd_in, cmd_out;
  logic      push, pop, full, empty;

  kdeq_front #(
    .NUM_KEYS (NUM_KEYS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .fifo_full_i (full),
    .busy_o      (busy_o),
    .push_o      (push),
    .cmd_o       (cmd_in)
  );

  kdeq_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .pop_i   (pop),
    .cmd_o   (cmd_out),
    .full_o  (full),
    .empty_o (empty)
  );

  kdeq_back #(
    .RING_SLOTS (RING_SLOTS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_out),
    .empty_i (empty),
    .pop_o   (pop),
    .done_o  (done_o),
    .res_o   (res_o)
  );

endmodule
